FILE: src/modular_arithmetic_unit_top_defines.svh
// ----------------------------------------------------------------------------
// Modular arithmetic unit assertion macros
// Shared assertion macros, empty when the SYNTHESIS macro is defined.
// ----------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("modular arithmetic unit assertion failed");
`define MAU_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("modular arithmetic unit forbidden condition seen");
`else
`define MAU_ASSERT(lbl, prop)
`define MAU_NEVER(lbl, expr)
`endif

`endif

FILE: src/mau_pkg.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit package
// Operation and status codes and the shared restoring division step.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned ModW  = 31;
  localparam int unsigned ProdW = 2 * ModW;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_OP   = 2'd2
  } st_e;

  // One bit of restoring division: returns the quotient bit and the new remainder.
  function automatic logic [ModW:0] div_step(input logic [ModW-1:0] rem,
                                             input logic            bit_in,
                                             input logic [ModW-1:0] dsr);
    logic [ModW:0] t;
    logic          ge;
    t  = {rem, bit_in};
    ge = (t >= {1'b0, dsr});
    return {ge, ge ? ModW'(t - {1'b0, dsr}) : t[ModW-1:0]};
  endfunction

endpackage

FILE: src/modular_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit
// Reduces two signed operands modulo a configured modulus and combines them.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start_i is high; busy_o is always
// low, so a new request may be issued in every cycle. Each request carries
// op_i, operand_a_i and operand_b_i. Its answer appears on result_o and
// status_o for exactly one cycle, marked by done_o, in request order.
// Throughput is one request per cycle. The unit is built from two
// bit-serial pipelines: 32 stages that reduce both operand magnitudes
// modulo the modulus, and 62 stages of restoring division that produce
// the final remainder or quotient.
// The modulus is written with cfg_we_i and cfg_modulus_i; the user must do
// so only while no request is in flight, as the block does not enforce it.
// A modulus of zero acts as one. Reset sets the modulus to one and drops
// every request in flight. The receiver cannot stall: no back-pressure path.
// ----------------------------------------------------------------------------
`include "modular_arithmetic_unit_top_defines.svh"

module modular_arithmetic_unit_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mau_pkg::ModW-1:0]    cfg_modulus_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [mau_pkg::OpW-1:0]     op_i,
  input  logic signed [mau_pkg::DataW-1:0] operand_a_i,
  input  logic signed [mau_pkg::DataW-1:0] operand_b_i,
  output logic                        done_o,
  output logic [mau_pkg::ModW-1:0]    result_o,
  output logic [mau_pkg::StW-1:0]     status_o
);

  localparam int unsigned ResStages = mau_pkg::DataW;
  localparam int unsigned DivStages = mau_pkg::ProdW;
  localparam int unsigned Latency   = ResStages + DivStages + 4;

  logic [mau_pkg::ModW-1:0] modulus_q;
  logic [mau_pkg::ModW-1:0] m_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mau_pkg::ModW'(1);
    end else if (cfg_we_i) begin
      modulus_q <= cfg_modulus_i;
    end
  end

  assign m_eff  = (modulus_q == '0) ? mau_pkg::ModW'(1) : modulus_q;
  assign busy_o = 1'b0;

  // Residue pipeline.
  logic                       rv_q   [0:ResStages];
  logic [mau_pkg::OpW-1:0]    rop_q  [0:ResStages];
  logic                       ran_q  [0:ResStages];
  logic                       rbn_q  [0:ResStages];
  logic [mau_pkg::DataW-1:0]  ram_q  [0:ResStages];
  logic [mau_pkg::DataW-1:0]  rbm_q  [0:ResStages];
  logic [mau_pkg::ModW-1:0]   rar_q  [0:ResStages];
  logic [mau_pkg::ModW-1:0]   rbr_q  [0:ResStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q[0] <= 1'b0;
    end else begin
      rv_q[0] <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rop_q[0] <= op_i;
    ran_q[0] <= operand_a_i[mau_pkg::DataW-1];
    rbn_q[0] <= operand_b_i[mau_pkg::DataW-1];
    ram_q[0] <= operand_a_i[mau_pkg::DataW-1] ? (~operand_a_i + 1'b1) : operand_a_i;
    rbm_q[0] <= operand_b_i[mau_pkg::DataW-1] ? (~operand_b_i + 1'b1) : operand_b_i;
    rar_q[0] <= '0;
    rbr_q[0] <= '0;
  end

  for (genvar gi = 0; gi < ResStages; gi++) begin : g_res
    logic [mau_pkg::ModW:0] sa;
    logic [mau_pkg::ModW:0] sb;

    assign sa = mau_pkg::div_step(rar_q[gi], ram_q[gi][mau_pkg::DataW-1], m_eff);
    assign sb = mau_pkg::div_step(rbr_q[gi], rbm_q[gi][mau_pkg::DataW-1], m_eff);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[gi+1] <= 1'b0;
      end else begin
        rv_q[gi+1] <= rv_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      rop_q[gi+1] <= rop_q[gi];
      ran_q[gi+1] <= ran_q[gi];
      rbn_q[gi+1] <= rbn_q[gi];
      ram_q[gi+1] <= {ram_q[gi][mau_pkg::DataW-2:0], 1'b0};
      rbm_q[gi+1] <= {rbm_q[gi][mau_pkg::DataW-2:0], 1'b0};
      rar_q[gi+1] <= sa[mau_pkg::ModW-1:0];
      rbr_q[gi+1] <= sb[mau_pkg::ModW-1:0];
    end
  end

  // Sign fix-up of the residues.
  logic                     f_vld_q;
  logic [mau_pkg::OpW-1:0]  f_op_q;
  logic [mau_pkg::ModW-1:0] fa_q;
  logic [mau_pkg::ModW-1:0] fb_q;
  logic [mau_pkg::ModW-1:0] fa_d;
  logic [mau_pkg::ModW-1:0] fb_d;

  assign fa_d = (ran_q[ResStages] && (rar_q[ResStages] != '0)) ?
                (m_eff - rar_q[ResStages]) : rar_q[ResStages];
  assign fb_d = (rbn_q[ResStages] && (rbr_q[ResStages] != '0)) ?
                (m_eff - rbr_q[ResStages]) : rbr_q[ResStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= rv_q[ResStages];
    end
  end

  always_ff @(posedge clk_i) begin
    f_op_q <= rop_q[ResStages];
    fa_q   <= fa_d;
    fb_q   <= fb_d;
  end

  // Operation select: every answer leaves through the division pipeline.
  logic                       dv_q  [0:DivStages];
  logic [mau_pkg::ProdW-1:0]  dnd_q [0:DivStages];
  logic [mau_pkg::ModW-1:0]   dsr_q [0:DivStages];
  logic [mau_pkg::ModW-1:0]   drm_q [0:DivStages];
  logic [mau_pkg::ModW-1:0]   dqt_q [0:DivStages];
  logic                       dsel_q[0:DivStages];
  logic [mau_pkg::StW-1:0]    dst_q [0:DivStages];

  logic [mau_pkg::ProdW-1:0]  dnd_d;
  logic [mau_pkg::ModW-1:0]   dsr_d;
  logic                       dsel_d;
  logic [mau_pkg::StW-1:0]    dst_d;
  logic [mau_pkg::ProdW-1:0]  prod;
  logic [mau_pkg::ModW:0]     sum;
  logic [mau_pkg::ModW:0]     dif;

  assign prod = fa_q * fb_q;
  assign sum  = {1'b0, fa_q} + {1'b0, fb_q};
  assign dif  = {1'b0, fa_q} + {1'b0, m_eff} - {1'b0, fb_q};

  always_comb begin
    dnd_d  = '0;
    dsr_d  = m_eff;
    dsel_d = 1'b0;
    dst_d  = mau_pkg::ST_OK;
    case (f_op_q)
      mau_pkg::OP_ADD: begin
        dnd_d = mau_pkg::ProdW'(sum);
      end
      mau_pkg::OP_SUB: begin
        dnd_d = mau_pkg::ProdW'(dif);
      end
      mau_pkg::OP_MUL: begin
        dnd_d = prod;
      end
      mau_pkg::OP_DIV: begin
        dnd_d  = mau_pkg::ProdW'(fa_q);
        dsr_d  = fb_q;
        dsel_d = 1'b1;
        if (fb_q == '0) begin
          dst_d = mau_pkg::ST_DIV_ZERO;
        end
      end
      mau_pkg::OP_REM: begin
        dnd_d = mau_pkg::ProdW'(fa_q);
        dsr_d = fb_q;
        if (fb_q == '0) begin
          dst_d = mau_pkg::ST_DIV_ZERO;
        end
      end
      default: begin
        dst_d = mau_pkg::ST_BAD_OP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dnd_q[0]  <= dnd_d;
    dsr_q[0]  <= dsr_d;
    drm_q[0]  <= '0;
    dqt_q[0]  <= '0;
    dsel_q[0] <= dsel_d;
    dst_q[0]  <= dst_d;
  end

  for (genvar gi = 0; gi < DivStages; gi++) begin : g_div
    logic [mau_pkg::ModW:0] st;

    assign st = mau_pkg::div_step(drm_q[gi], dnd_q[gi][mau_pkg::ProdW-1], dsr_q[gi]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[gi+1] <= 1'b0;
      end else begin
        dv_q[gi+1] <= dv_q[gi];
      end
    end

    always_ff @(posedge clk_i) begin
      dnd_q[gi+1]  <= {dnd_q[gi][mau_pkg::ProdW-2:0], 1'b0};
      dsr_q[gi+1]  <= dsr_q[gi];
      drm_q[gi+1]  <= st[mau_pkg::ModW-1:0];
      dqt_q[gi+1]  <= {dqt_q[gi][mau_pkg::ModW-2:0], st[mau_pkg::ModW]};
      dsel_q[gi+1] <= dsel_q[gi];
      dst_q[gi+1]  <= dst_q[gi];
    end
  end

  // Output register; idle cycles show zeros.
  logic                     done_q;
  logic [mau_pkg::ModW-1:0] result_q;
  logic [mau_pkg::StW-1:0]  status_q;
  logic [mau_pkg::ModW-1:0] result_d;
  logic [mau_pkg::StW-1:0]  status_d;

  always_comb begin
    result_d = '0;
    status_d = mau_pkg::ST_OK;
    if (dv_q[DivStages]) begin
      status_d = dst_q[DivStages];
      if (dst_q[DivStages] == mau_pkg::ST_OK) begin
        result_d = dsel_q[DivStages] ? dqt_q[DivStages] : drm_q[DivStages];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      result_q <= '0;
      status_q <= mau_pkg::ST_OK;
    end else begin
      done_q   <= dv_q[DivStages];
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;
  assign status_o = status_q;

  `MAU_ASSERT(a_latency, start_i |-> ##Latency done_o)
  `MAU_ASSERT(a_err_zero, (status_o != mau_pkg::ST_OK) |-> (result_o == '0))
  `MAU_NEVER(a_idle_quiet, !done_o && ((result_o != '0) || (status_o != mau_pkg::ST_OK)))

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Modular arithmetic unit testbench
// Drives signed operand pairs and op codes under several modulus settings and
// idle patterns, and checks every answer against an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Latency = 98;
  localparam logic [mau_pkg::OpW-1:0] OpBad5 = 3'd5;
  localparam logic [mau_pkg::OpW-1:0] OpBad7 = 3'd7;

  typedef struct packed {
    logic [mau_pkg::OpW-1:0]   op;
    logic [mau_pkg::DataW-1:0] a;
    logic [mau_pkg::DataW-1:0] b;
  } request_t;

  typedef struct packed {
    logic [mau_pkg::ModW-1:0] result;
    logic [mau_pkg::StW-1:0]  status;
  } answer_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [mau_pkg::ModW-1:0]         cfg_modulus_i;
  logic                             start_i;
  logic                             busy_o;
  logic [mau_pkg::OpW-1:0]          op_i;
  logic signed [mau_pkg::DataW-1:0] operand_a_i;
  logic signed [mau_pkg::DataW-1:0] operand_b_i;
  logic                             done_o;
  logic [mau_pkg::ModW-1:0]         result_o;
  logic [mau_pkg::StW-1:0]          status_o;

  request_t                 pending_q[$];
  answer_t                  answers_q[$];
  logic [mau_pkg::ModW-1:0] modulus_r;
  int                       errors;
  int                       idle_pct;
  bit                       stim_done;

  modular_arithmetic_unit_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_modulus_i, .start_i, .busy_o,
    .op_i, .operand_a_i, .operand_b_i, .done_o, .result_o, .status_o
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  function automatic logic [63:0] residue_of(logic [mau_pkg::DataW-1:0] v, logic [63:0] m);
    logic [63:0] mag;
    logic [63:0] r;
    if (v[mau_pkg::DataW-1]) begin
      mag = 64'h1_0000_0000 - {32'd0, v};
      r   = mag % m;
      return (r == 0) ? 64'd0 : m - r;
    end
    return {32'd0, v} % m;
  endfunction

  function automatic answer_t modular_answer(request_t rq, logic [mau_pkg::ModW-1:0] mod);
    logic [63:0] m;
    logic [63:0] ra;
    logic [63:0] rb;
    answer_t     ans;
    m  = (mod == 0) ? 64'd1 : {33'd0, mod};
    ra = residue_of(rq.a, m);
    rb = residue_of(rq.b, m);
    ans.result = '0;
    ans.status = mau_pkg::ST_OK;
    case (rq.op)
      mau_pkg::OP_ADD: ans.result = mau_pkg::ModW'((ra + rb) % m);
      mau_pkg::OP_SUB: ans.result = mau_pkg::ModW'((ra + m - rb) % m);
      mau_pkg::OP_MUL: ans.result = mau_pkg::ModW'((ra * rb) % m);
      mau_pkg::OP_DIV, mau_pkg::OP_REM: begin
        if (rb == 0) ans.status = mau_pkg::ST_DIV_ZERO;
        else if (rq.op == mau_pkg::OP_DIV) ans.result = mau_pkg::ModW'((ra / rb) % m);
        else ans.result = mau_pkg::ModW'((ra % rb) % m);
      end
      default: ans.status = mau_pkg::ST_BAD_OP;
    endcase
    return ans;
  endfunction

  // Driver: one request per cycle at most, presented at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      answers_q.push_back(modular_answer(pending_q.pop_front(), modulus_r));
    end
    if (rst_ni && pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start_i     <= 1'b1;
      op_i        <= pending_q[0].op;
      operand_a_i <= pending_q[0].a;
      operand_b_i <= pending_q[0].b;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected answer result=%0d status=%0d", $time, result_o, status_o);
        errors++;
      end else begin
        answer_t exp_ans;
        exp_ans = answers_q.pop_front();
        if (exp_ans.result !== result_o)
          $display("%0t: result expected %0d actual %0d", $time, exp_ans.result, result_o);
        if (exp_ans.status !== status_o)
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.status, status_o);
        if (exp_ans.result !== result_o || exp_ans.status !== status_o) errors++;
      end
    end
  end

  function automatic logic [mau_pkg::DataW-1:0] rand_operand(logic [mau_pkg::ModW-1:0] mod);
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return mau_pkg::DataW'($urandom_range(3)) - 32'd1;
      3: return {1'b0, mod} * mau_pkg::DataW'($urandom_range(3));
      4: return -({1'b0, mod} * mau_pkg::DataW'($urandom_range(2)));
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    wait (pending_q.size() == 0 && !start_i);
    wait (answers_q.size() == 0);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic set_modulus(logic [mau_pkg::ModW-1:0] value);
    @(negedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_modulus_i <= value;
    modulus_r     <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_request(logic [mau_pkg::OpW-1:0] op, logic [mau_pkg::DataW-1:0] a,
                               logic [mau_pkg::DataW-1:0] b);
    request_t rq;
    rq.op = op;
    rq.a  = a;
    rq.b  = b;
    pending_q.push_back(rq);
  endtask

  initial begin
    logic [mau_pkg::ModW-1:0] moduli[8];
    int                       idles[4];
    errors        = 0;
    stim_done     = 0;
    idle_pct      = 0;
    modulus_r     = 31'd1;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_modulus_i = '0;
    start_i       = 1'b0;
    op_i          = '0;
    operand_a_i   = '0;
    operand_b_i   = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset modulus of one, then a mid-size and the largest modulus with directed corners.
    for (int op = 0; op < 8; op++) begin
      queue_request(mau_pkg::OpW'(op), 32'h8000_0000, 32'h7fff_ffff);
    end
    drain();
    set_modulus(31'd1000);
    queue_request(mau_pkg::OP_ADD, 32'hffff_ffff, 32'h8000_0000);
    queue_request(mau_pkg::OP_SUB, 32'd0, 32'd1);
    queue_request(mau_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0000);
    queue_request(mau_pkg::OP_DIV, 32'd999, 32'd0);
    queue_request(mau_pkg::OP_REM, 32'd999, 32'd0);
    queue_request(mau_pkg::OP_DIV, 32'd999, -32'sd2000);
    queue_request(mau_pkg::OP_REM, -32'sd7, 32'd3);
    queue_request(mau_pkg::OP_DIV, -32'sd1, 32'd7);
    queue_request(OpBad5, 32'd5, 32'd5);
    queue_request(OpBad7, 32'hffff_ffff, 32'hffff_ffff);
    drain();
    set_modulus(31'h7fff_ffff);
    queue_request(mau_pkg::OP_MUL, 32'h7fff_fffe, 32'hffff_ffff);
    queue_request(mau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    queue_request(mau_pkg::OP_ADD, 32'h7fff_fffe, 32'h7fff_fffe);
    queue_request(mau_pkg::OP_DIV, 32'h7fff_fffe, 32'd1);
    drain();

    moduli = '{31'd0, 31'd1, 31'd2, 31'd7, 31'd1000, 31'd65521, 31'h7fff_ffff, 31'h4000_0001};
    idles  = '{0, 61, 17, 61};
    for (int ph = 0; ph < 8; ph++) begin
      set_modulus(ph == 7 ? mau_pkg::ModW'($urandom) : moduli[ph]);
      idle_pct = idles[ph % 4];
      for (int i = 0; i < 90; i++) begin
        queue_request(mau_pkg::OpW'($urandom_range(9) > 8 ? $urandom_range(7, 5) :
                                    $urandom_range(4)),
                      rand_operand(modulus_r), rand_operand(modulus_r));
        if (ph == 3 && i == 45) begin
          wait (pending_q.size() == 0);
          wait (answers_q.size() == 0);
        end
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
